### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TTPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ttps check failed");

// Check a property on every rising clock edge, reset included.
`define TTPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ttps check failed");

`endif

### src/ttps_pkg.sv
package ttps_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned BOUND_W = 2;
  localparam int unsigned AGE_W   = 8;

  typedef enum logic {
    FUNC_PROBE = 1'b0,
    FUNC_STORE = 1'b1
  } func_e;

  typedef enum logic [BOUND_W-1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2
  } bound_e;

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [AGE_W-1:0]          age;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### src/transposition_table_probe_store.sv
// Channel | Direction | Handshake             | Word
// --------+-----------+-----------------------+--------------------------------------------
// in      | input     | in_valid_i/in_stall_o | func, key, depth, alpha, beta, entry fields
// out     | output    | out_valid_o/out_stall_i | known, result_value, best_move
//
// A store passes through accept and slot write; a probe through accept, slot read and
// compare into the output register. A table size that is not a power of two adds
// key reduction before the slot access, 4 key bits a cycle. After reset the block
// clears the table one slot a cycle, with in_stall_o high. A stalled
// result holds the probe in its compare step until the output register frees up.
module transposition_table_probe_store #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [ttps_pkg::KEY_W-1:0]         hash_key_i,
  input  logic [ttps_pkg::DEPTH_W-1:0]       search_depth_i,
  input  logic signed [ttps_pkg::SCORE_W-1:0] window_low_i,
  input  logic signed [ttps_pkg::SCORE_W-1:0] window_high_i,
  input  logic signed [ttps_pkg::SCORE_W-1:0] store_eval_i,
  input  logic [ttps_pkg::MOVE_W-1:0]        store_move_i,
  input  logic [ttps_pkg::BOUND_W-1:0]       store_bound_i,
  input  logic [ttps_pkg::AGE_W-1:0]         store_age_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               known_o,
  output logic signed [ttps_pkg::SCORE_W-1:0] result_value_o,
  output logic [ttps_pkg::MOVE_W-1:0]        best_move_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_INDEX  = 4'b0100,
    ST_LOOKUP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0] clr_q;
  logic            in_accept;
  logic            idx_done;
  logic [IdxW-1:0] idx;

  logic                                func_q;
  logic [ttps_pkg::KEY_W-1:0]          key_q;
  logic [ttps_pkg::DEPTH_W-1:0]        depth_q;
  logic signed [ttps_pkg::SCORE_W-1:0] alpha_q;
  logic signed [ttps_pkg::SCORE_W-1:0] beta_q;
  logic signed [ttps_pkg::SCORE_W-1:0] eval_q;
  logic [ttps_pkg::MOVE_W-1:0]         move_q;
  logic [ttps_pkg::BOUND_W-1:0]        bound_q;
  logic [ttps_pkg::AGE_W-1:0]          age_q;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  ttps_pkg::entry_t  wr_data;
  logic              rd_en;
  ttps_pkg::entry_t  rd_data;

  logic                                hit;
  logic                                known_d;
  logic signed [ttps_pkg::SCORE_W-1:0] value_d;
  logic [ttps_pkg::MOVE_W-1:0]         best_d;
  logic                                out_load;

  logic                                out_valid_q;
  logic                                known_q;
  logic signed [ttps_pkg::SCORE_W-1:0] value_q;
  logic [ttps_pkg::MOVE_W-1:0]         best_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);

  ttps_index_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .key_i  (hash_key_i),
    .done_o (idx_done),
    .index_o(idx)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q  <= func_i;
      key_q   <= hash_key_i;
      depth_q <= search_depth_i;
      alpha_q <= window_low_i;
      beta_q  <= window_high_i;
      eval_q  <= store_eval_i;
      move_q  <= store_move_i;
      bound_q <= store_bound_i;
      age_q   <= store_age_i;
    end
  end

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_q == IdxW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          if (ttps_pkg::func_e'(func_q) == ttps_pkg::FUNC_STORE) begin
            wr_en   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    wr_addr = idx;
    wr_data = '{valid: 1'b1, key: key_q, depth: depth_q, move: move_q,
                score: eval_q, bound: bound_q, age: age_q};
    if (state_q == ST_CLEAR) begin
      wr_addr = clr_q;
      wr_data = '0;
    end
  end

  ttps_entry_mem #(
    .DEPTH(TABLE_ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx),
    .rd_data_o(rd_data)
  );

  always_comb begin
    hit     = rd_data.valid && (rd_data.key == key_q) && (rd_data.depth >= depth_q);
    best_d  = rd_data.valid ? rd_data.move : '0;
    known_d = 1'b0;
    case (ttps_pkg::bound_e'(rd_data.bound))
      ttps_pkg::BOUND_EXACT: begin
        known_d = hit;
        value_d = rd_data.score;
      end
      ttps_pkg::BOUND_UPPER: begin
        known_d = hit && (rd_data.score <= alpha_q);
        value_d = alpha_q;
      end
      default: begin
        known_d = hit && (rd_data.score >= beta_q);
        value_d = beta_q;
      end
    endcase
    if (!known_d) begin
      value_d = '0;
    end
  end

  assign out_load = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      known_q <= known_d;
      value_q <= value_d;
      best_q  <= best_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign known_o        = known_q;
  assign result_value_o = value_q;
  assign best_move_o    = best_q;

endmodule

### src/ttps_index_unit.sv
module ttps_index_unit #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ttps_pkg::KEY_W-1:0]        key_i,
  output logic                              done_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  index_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam bit          IsPow2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  logic done_q;

  assign done_o = done_q;

  if (IsPow2) begin : g_pow2
    logic [IdxW-1:0] idx_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_q <= key_i[IdxW-1:0];
      end
    end

    assign index_o = idx_q;
  end else begin : g_reduce
    localparam int unsigned Steps  = 4;
    localparam int unsigned Cycles = ttps_pkg::KEY_W / Steps;
    localparam int unsigned CntW   = $clog2(Cycles);

    logic                       busy_q;
    logic [CntW-1:0]            cnt_q;
    logic [ttps_pkg::KEY_W-1:0] key_q;
    logic [IdxW-1:0]            rem_q;
    logic [IdxW-1:0]            rem_d;

    always_comb begin
      logic [IdxW:0] t;
      rem_d = rem_q;
      for (int i = 0; i < Steps; i++) begin
        t = {rem_d, key_q[ttps_pkg::KEY_W-1-i]};
        if (t >= (IdxW+1)'(TABLE_ENTRIES)) begin
          t = t - (IdxW+1)'(TABLE_ENTRIES);
        end
        rem_d = t[IdxW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(Cycles - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
        rem_q <= '0;
      end else if (busy_q) begin
        key_q <= key_q << Steps;
        rem_q <= rem_d;
      end
    end

    assign index_o = rem_q;
  end

endmodule

### src/ttps_entry_mem.sv
module ttps_entry_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  ttps_pkg::entry_t           wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output ttps_pkg::entry_t           rd_data_o
);

  logic [ttps_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [ttps_pkg::ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = ttps_pkg::entry_t'(rd_data_q);

endmodule

### src/ttps_checker.sv
`include "assert_macros.svh"

module ttps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               known_o,
  input logic signed [ttps_pkg::SCORE_W-1:0] result_value_o,
  input logic [ttps_pkg::MOVE_W-1:0]        best_move_o
);

  logic [ttps_pkg::SCORE_W+ttps_pkg::MOVE_W:0] out_word;

  assign out_word = {known_o, result_value_o, best_move_o};

  `TTPS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `TTPS_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_word))
  `TTPS_ASSERT(a_unknown_zero, out_valid_o && !known_o |-> result_value_o == '0)
  `TTPS_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)
  `TTPS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && in_stall_o)

endmodule

bind transposition_table_probe_store ttps_checker u_ttps_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned KEY_W   = ttps_pkg::KEY_W;
  localparam int unsigned DEPTH_W = ttps_pkg::DEPTH_W;
  localparam int unsigned SCORE_W = ttps_pkg::SCORE_W;
  localparam int unsigned MOVE_W  = ttps_pkg::MOVE_W;
  localparam int unsigned BOUND_W = ttps_pkg::BOUND_W;
  localparam int unsigned AGE_W   = ttps_pkg::AGE_W;

  localparam int unsigned SLOTS = 4096;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [BOUND_W-1:0] BOUND_SPARE = 2'd3;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;

  typedef struct packed {
    ttps_pkg::func_e           func;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] eval;
    logic [MOVE_W-1:0]         move;
    logic [BOUND_W-1:0]        bound;
    logic [AGE_W-1:0]          age;
  } word_t;

  typedef struct packed {
    logic                      known;
    logic signed [SCORE_W-1:0] value;
    logic [MOVE_W-1:0]         move;
  } result_t;

  typedef struct packed {
    word_t   w;
    logic    fixed;
    result_t res;
  } row_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] eval;
  } note_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b1;
  logic    in_valid_i = 1'b0;
  logic    out_stall_i = 1'b0;
  word_t   drv_word = '0;
  logic    drv_fixed = 1'b0;
  result_t drv_expect = '0;
  logic    in_stall_o;
  logic    out_valid_o;
  logic    known_o;
  logic signed [SCORE_W-1:0] result_value_o;
  logic [MOVE_W-1:0] best_move_o;

  ttps_pkg::entry_t slot_image [SLOTS];
  result_t due_results [$];
  row_t    directed_rows [$];
  note_t   stored_notes [$];
  bit      calm = 1'b1;
  int      err_count = 0;
  int      cycle_count = 0;

  transposition_table_probe_store #(
    .TABLE_ENTRIES(SLOTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (drv_word.func),
    .hash_key_i    (drv_word.key),
    .search_depth_i(drv_word.depth),
    .window_low_i  (drv_word.alpha),
    .window_high_i (drv_word.beta),
    .store_eval_i  (drv_word.eval),
    .store_move_i  (drv_word.move),
    .store_bound_i (drv_word.bound),
    .store_age_i   (drv_word.age),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .known_o       (known_o),
    .result_value_o(result_value_o),
    .best_move_o   (best_move_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t lookup_slot(input word_t w);
    result_t          r;
    ttps_pkg::entry_t e;
    r = '0;
    e = slot_image[w.key[SLOT_W-1:0]];
    if (e.valid) begin
      r.move = e.move;
      if (e.key == w.key && e.depth >= w.depth) begin
        case (e.bound)
          ttps_pkg::BOUND_EXACT: begin
            r.known = 1'b1;
            r.value = e.score;
          end
          ttps_pkg::BOUND_UPPER: begin
            if (e.score <= w.alpha) begin
              r.known = 1'b1;
              r.value = w.alpha;
            end
          end
          default: begin
            if (e.score >= w.beta) begin
              r.known = 1'b1;
              r.value = w.beta;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic void put_store(input logic [KEY_W-1:0] k, input logic [DEPTH_W-1:0] d,
                                    input logic signed [SCORE_W-1:0] ev,
                                    input logic [MOVE_W-1:0] mv,
                                    input logic [BOUND_W-1:0] bd, input logic [AGE_W-1:0] ag);
    row_t r;
    r = '0;
    r.w.func = ttps_pkg::FUNC_STORE;
    r.w.key = k;
    r.w.depth = d;
    r.w.eval = ev;
    r.w.move = mv;
    r.w.bound = bd;
    r.w.age = ag;
    directed_rows.push_back(r);
  endfunction

  function automatic void put_probe(input logic [KEY_W-1:0] k, input logic [DEPTH_W-1:0] d,
                                    input logic signed [SCORE_W-1:0] al,
                                    input logic signed [SCORE_W-1:0] be,
                                    input logic fx, input logic kn,
                                    input logic signed [SCORE_W-1:0] val,
                                    input logic [MOVE_W-1:0] mv);
    row_t r;
    r = '0;
    r.w.func = ttps_pkg::FUNC_PROBE;
    r.w.key = k;
    r.w.depth = d;
    r.w.alpha = al;
    r.w.beta = be;
    r.fixed = fx;
    r.res.known = kn;
    r.res.value = val;
    r.res.move = mv;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(input word_t w, input logic fx, input result_t res);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drv_word <= w;
    drv_fixed <= fx;
    drv_expect <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t          want;
    ttps_pkg::entry_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: known %0b value %0d move %h",
                   known_o, result_value_o, best_move_o);
      end else begin
        want = due_results.pop_front();
        if (known_o !== want.known || result_value_o !== want.value ||
            best_move_o !== want.move) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected known %0b value %0d move %h, got %0b %0d %h",
                     want.known, want.value, want.move,
                     known_o, result_value_o, best_move_o);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (drv_word.func == ttps_pkg::FUNC_STORE) begin
        e.valid = 1'b1;
        e.key = drv_word.key;
        e.depth = drv_word.depth;
        e.move = drv_word.move;
        e.score = drv_word.eval;
        e.bound = drv_word.bound;
        e.age = drv_word.age;
        slot_image[drv_word.key[SLOT_W-1:0]] = e;
      end else begin
        due_results.push_back(drv_fixed ? drv_expect : lookup_slot(drv_word));
      end
    end
  end

  initial begin
    word_t w;
    note_t nt;
    int    pick;
    int    a;
    int    b;
    rst_ni <= 1'b0;
    for (int i = 0; i < SLOTS; i++) slot_image[i] = '0;

    put_probe(64'h0, 8'd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'h0000);
    put_probe('1, 8'd255, SCORE_MIN, SCORE_MAX, 1'b1, 1'b0, 16'sd0, 16'h0000);
    put_store(64'h5, 8'd10, 16'sd100, 16'hABCD, ttps_pkg::BOUND_EXACT, 8'hFF);
    put_probe(64'h5, 8'd10, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd100, 16'hABCD);
    put_probe(64'h5, 8'd11, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'hABCD);
    put_probe(64'h1005, 8'd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'hABCD);
    put_store('1, 8'd255, SCORE_MIN, 16'hFFFF, ttps_pkg::BOUND_UPPER, 8'h00);
    put_probe('1, 8'd255, SCORE_MIN, 16'sd0, 1'b1, 1'b1, SCORE_MIN, 16'hFFFF);
    put_probe('1, 8'd0, SCORE_MAX, 16'sd0, 1'b1, 1'b1, SCORE_MAX, 16'hFFFF);
    put_store(64'h8000_0000_0000_0ABC, 8'd0, SCORE_MAX, 16'h0000, ttps_pkg::BOUND_LOWER,
              8'h5A);
    put_probe(64'h8000_0000_0000_0ABC, 8'd0, 16'sd0, SCORE_MAX, 1'b1, 1'b1, SCORE_MAX,
              16'h0000);
    put_probe(64'h8000_0000_0000_0ABC, 8'd0, 16'sd0, SCORE_MIN, 1'b1, 1'b1, SCORE_MIN,
              16'h0000);
    put_probe(64'h8000_0000_0000_0ABC, 8'd1, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'h0000);
    put_store(64'h777, 8'd7, 16'sd0, 16'h1234, BOUND_SPARE, 8'h80);
    put_probe(64'h777, 8'd3, 16'sd0, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'h0000);
    put_probe(64'h777, 8'd7, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'h0000);
    put_store(64'h5, 8'd3, -16'sd200, 16'h00C3, ttps_pkg::BOUND_UPPER, 8'h01);
    put_probe(64'h5, 8'd3, -16'sd201, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'h0000);
    put_probe(64'h5, 8'd2, -16'sd200, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'h0000);
    put_store(64'h1005, 8'd9, 16'sd50, 16'h7E7E, ttps_pkg::BOUND_EXACT, 8'h02);
    put_probe(64'h5, 8'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'h0000);
    put_probe(64'h1005, 8'd9, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'h0000);
    put_probe(64'h0, 8'd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'h0000);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].fixed, directed_rows[i].res);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 150 && n < 250);
      w.key = {$urandom, $urandom};
      w.depth = DEPTH_W'($urandom);
      w.alpha = SCORE_W'($urandom);
      w.beta = SCORE_W'($urandom);
      w.eval = SCORE_W'($urandom);
      w.move = MOVE_W'($urandom);
      w.bound = BOUND_W'($urandom_range(3));
      w.age = AGE_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
        w.func = ttps_pkg::FUNC_STORE;
        if (stored_notes.size() != 0) begin
          nt = stored_notes[$urandom_range(stored_notes.size() - 1)];
          a = $urandom_range(99);
          if (a < 35)
            w.key = nt.key;
          else if (a < 55)
            w.key[SLOT_W-1:0] = nt.key[SLOT_W-1:0];
        end
        if ($urandom_range(9) == 0) w.move = '0;
        case ($urandom_range(9))
          0: w.eval = SCORE_MIN;
          1: w.eval = SCORE_MAX;
          default: ;
        endcase
        nt.key = w.key;
        nt.depth = w.depth;
        nt.eval = w.eval;
        stored_notes.push_back(nt);
        if (stored_notes.size() > 48) void'(stored_notes.pop_front());
      end else begin
        w.func = ttps_pkg::FUNC_PROBE;
        if (pick < 90 && stored_notes.size() != 0) begin
          nt = stored_notes[$urandom_range(stored_notes.size() - 1)];
          w.key = nt.key;
          if ($urandom_range(9) == 0) w.key[KEY_W-1 - $urandom_range(KEY_W-1-SLOT_W)] ^= 1'b1;
          if ($urandom_range(9) < 7) w.depth = DEPTH_W'($urandom_range(nt.depth));
          if ($urandom_range(9) < 6) begin
            a = int'(nt.eval) + int'($urandom_range(16)) - 8;
            b = int'(nt.eval) + int'($urandom_range(16)) - 8;
            if (a > 32767) a = 32767;
            if (a < -32768) a = -32768;
            if (b > 32767) b = 32767;
            if (b < -32768) b = -32768;
            w.alpha = SCORE_W'(a);
            w.beta = SCORE_W'(b);
          end
        end
      end
      send_word(w, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && due_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
